// ===== rtl/psw_pkg.sv =====
// Package for the planar span write generator.
// Holds the shared types, constants and mask tables. No dependencies.
package psw_pkg;

    localparam logic [8:0] ROW_BYTES = 9'd80;

    // Configuration register indexes
    localparam logic [2:0] REG_CLIP_MIN_X = 3'd0;
    localparam logic [2:0] REG_CLIP_MAX_X = 3'd1;
    localparam logic [2:0] REG_CLIP_MIN_Y = 3'd2;
    localparam logic [2:0] REG_CLIP_MAX_Y = 3'd3;
    localparam logic [2:0] REG_PAGE_BASE  = 3'd4;

    localparam logic [3:0] MASK_ALL = 4'hF;

    typedef struct packed {
        logic [9:0]  clip_min_x;
        logic [10:0] clip_max_x;
        logic [9:0]  clip_min_y;
        logic [10:0] clip_max_y;
        logic [15:0] page_base;
    } cfg_t;

    // One clipped span, ready to be split into writes
    typedef struct packed {
        logic [15:0] addr;
        logic [3:0]  lmask;
        logic [3:0]  rmask;
        logic [8:0]  n;
        logic [7:0]  color;
        logic [1:0]  last_idx;
    } plan_t;

    function automatic logic [3:0] left_mask(input logic [1:0] x);
        case (x)
            2'd0:    left_mask = 4'hF;
            2'd1:    left_mask = 4'hE;
            2'd2:    left_mask = 4'hC;
            default: left_mask = 4'h8;
        endcase
    endfunction

    function automatic logic [3:0] right_mask(input logic [1:0] x);
        case (x)
            2'd0:    right_mask = 4'h1;
            2'd1:    right_mask = 4'h3;
            2'd2:    right_mask = 4'h7;
            default: right_mask = 4'hF;
        endcase
    endfunction

endpackage

// ===== rtl/psw_cfg_regs.sv =====
// Configuration register file of the planar span write generator.
// Depends on psw_pkg.
module psw_cfg_regs (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_wdata,
    output psw_pkg::cfg_t  cfg
);
    import psw_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clip_min_x <= 10'd0;
            cfg_reg.clip_max_x <= 11'd320;
            cfg_reg.clip_min_y <= 10'd0;
            cfg_reg.clip_max_y <= 11'd240;
            cfg_reg.page_base  <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CLIP_MIN_X: cfg_reg.clip_min_x <= cfg_wdata[9:0];
                REG_CLIP_MAX_X: cfg_reg.clip_max_x <= cfg_wdata[10:0];
                REG_CLIP_MIN_Y: cfg_reg.clip_min_y <= cfg_wdata[9:0];
                REG_CLIP_MAX_Y: cfg_reg.clip_max_y <= cfg_wdata[10:0];
                REG_PAGE_BASE:  cfg_reg.page_base  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/psw_span_plan.sv =====
// Clip and address logic: turns one registered span into a write plan.
// Depends on psw_pkg.
module psw_span_plan (
    input  logic [11:0]    row,
    input  logic [11:0]    span_left,
    input  logic [11:0]    span_right,
    input  logic [7:0]     fill_color,
    input  psw_pkg::cfg_t  cfg,
    output psw_pkg::plan_t plan,
    output logic           keep
);
    import psw_pkg::*;

    logic signed [12:0] row_s, xs_s, xe_s;
    logic signed [12:0] min_x_s, max_x_s, min_y_s, max_y_s;
    logic signed [12:0] xs_c, xe_c;
    logic [10:0] row_u, xs_u, xe_u, n_full;
    logic [19:0] row_off;

    always_comb begin
        row_s   = 13'(signed'(row));
        xs_s    = 13'(signed'(span_left));
        xe_s    = 13'(signed'(span_right));
        min_x_s = signed'({3'b000, cfg.clip_min_x});
        max_x_s = signed'({2'b00, cfg.clip_max_x});
        min_y_s = signed'({3'b000, cfg.clip_min_y});
        max_y_s = signed'({2'b00, cfg.clip_max_y});

        xs_c = (xs_s < min_x_s) ? min_x_s : xs_s;
        xe_c = (xe_s >= max_x_s) ? (max_x_s - 13'sd1) : xe_s;

        keep = (row_s >= min_y_s) && (row_s < max_y_s) && !(xe_c < xs_c);

        // valid only when keep: all three are then non-negative
        row_u   = row_s[10:0];
        xs_u    = xs_c[10:0];
        xe_u    = xe_c[10:0];
        row_off = {9'b0, row_u} * {11'b0, ROW_BYTES};
        n_full  = xe_u - {xs_u[10:2], 2'b00};

        plan.addr  = cfg.page_base + row_off[15:0] + {7'b0, xs_u[10:2]};
        plan.lmask = left_mask(xs_u[1:0]);
        plan.rmask = right_mask(xe_u[1:0]);
        plan.n     = n_full[10:2];
        plan.color = fill_color;
        if (plan.n == 9'd0) begin
            plan.last_idx = 2'd0;
        end else if (plan.n == 9'd1) begin
            plan.last_idx = 2'd1;
        end else begin
            plan.last_idx = 2'd2;
        end
    end

endmodule

// ===== rtl/psw_write_seq.sv =====
// Plan register and write sequencer: emits up to three writes per span,
// one per cycle into the output register when free. Depends on psw_pkg.
module psw_write_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           plan_offer,
    input  logic           plan_keep,
    input  psw_pkg::plan_t plan_in,
    output logic           plan_take,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [39:0]    m_tdata,
    output logic           m_tlast
);
    import psw_pkg::*;

    plan_t       plan_reg;
    logic        plan_valid_reg, plan_valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic        m_valid_reg;
    logic [15:0] addr_reg, addr_next;
    logic [3:0]  mask_reg, mask_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  color_reg;
    logic        last_reg, last_next;
    logic        out_free, emit, plan_done;
    logic [15:0] addr_end;

    assign out_free  = !m_valid_reg || m_tready;
    assign emit      = plan_valid_reg && out_free;
    assign plan_done = emit && (idx_reg == plan_reg.last_idx);
    assign plan_take = plan_offer && (!plan_valid_reg || plan_done);
    assign addr_end  = plan_reg.addr + {7'b0, plan_reg.n};

    always_comb begin
        plan_valid_next = plan_valid_reg;
        idx_next        = idx_reg;
        if (plan_done) begin
            plan_valid_next = 1'b0;
            idx_next        = 2'd0;
        end else if (emit) begin
            idx_next = idx_reg + 2'd1;
        end
        if (plan_take) begin
            plan_valid_next = plan_keep;
        end

        // select the write for the current step
        addr_next  = addr_end;
        mask_next  = plan_reg.rmask;
        count_next = 9'd1;
        last_next  = 1'b1;
        case (idx_reg)
            2'd0: begin
                addr_next = plan_reg.addr;
                if (plan_reg.n == 9'd0) begin
                    mask_next = plan_reg.lmask & plan_reg.rmask;
                end else begin
                    mask_next = plan_reg.lmask;
                    last_next = 1'b0;
                end
            end
            2'd1: begin
                if (plan_reg.n != 9'd1) begin
                    addr_next  = plan_reg.addr + 16'd1;
                    mask_next  = MASK_ALL;
                    count_next = plan_reg.n - 9'd1;
                    last_next  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            plan_valid_reg <= plan_valid_next;
            idx_reg        <= idx_next;
            if (out_free) begin
                m_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (plan_take) begin
            plan_reg <= plan_in;
        end
        if (emit) begin
            addr_reg  <= addr_next;
            mask_reg  <= mask_next;
            count_reg <= count_next;
            color_reg <= plan_reg.color;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, color_reg, count_reg, mask_reg, addr_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/planar_span_write_generator.sv =====
// Top level of the planar span write generator.
// Depends on psw_pkg, psw_cfg_regs, psw_span_plan and psw_write_seq.
//
// Turns each horizontal span (row, start column, end column, color) into
// byte writes for a four-plane planar frame buffer with ROW_BYTES bytes per
// row. The span is dropped unless clip_min_y <= row < clip_max_y; the start
// is raised to clip_min_x and the end lowered to clip_max_x - 1, and a span
// left empty gives no writes. A surviving span gives a left write with a
// left edge plane mask, an optional full-mask middle fill over byte_count
// bytes, and a right write; a span inside one byte gives a single write with
// the merged mask. last_write (tlast) marks the final write of a span.
// Addresses are page_base + row*ROW_BYTES + (x>>2), modulo 65536.
// Data path: input register, clip/address logic, plan register, write
// sequencer, output register. A write passes through the input, plan and
// output registers in that order. The sequencer issues one write per cycle
// while the output register is free, and a span holds the plan register
// until its last write is issued; the plan register takes the next span as
// that write is issued. A dropped span gives no write and leaves the plan
// register free. Configuration is written through cfg_wr_en, cfg_index
// and cfg_wdata, and must only change while the block is idle.
module planar_span_write_generator (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // span input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // row[11:0], span_left[23:12],
                                  // span_right[35:24], fill_color[43:36]
    // write output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // byte_address[15:0], plane_mask[19:16],
                                  // byte_count[28:20], write_color[36:29]
    output logic        m_tlast   // last_write
);
    import psw_pkg::*;

    cfg_t        cfg;
    plan_t       plan;
    logic        plan_keep, plan_take;
    logic        in_valid_reg;
    logic [11:0] row_reg, left_reg, right_reg;
    logic [7:0]  color_reg;

    psw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Take a new span whenever the input register is empty or moves on
    assign s_tready = !in_valid_reg || plan_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Hold the span fields until the plan register takes them
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            row_reg   <= s_tdata[11:0];
            left_reg  <= s_tdata[23:12];
            right_reg <= s_tdata[35:24];
            color_reg <= s_tdata[43:36];
        end
    end

    psw_span_plan u_plan (
        .row        (row_reg),
        .span_left  (left_reg),
        .span_right (right_reg),
        .fill_color (color_reg),
        .cfg        (cfg),
        .plan       (plan),
        .keep       (plan_keep)
    );

    psw_write_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .plan_offer (in_valid_reg),
        .plan_keep  (plan_keep),
        .plan_in    (plan),
        .plan_take  (plan_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== dv/tb_planar_span_write_generator.sv =====
// Self-checking testbench for planar_span_write_generator.
// Predicts the byte writes of each span, scores every m_ transfer in order.
// Depends on psw_pkg and the RTL of the block; needs nothing else.
module tb_planar_span_write_generator;
    import psw_pkg::*;

    localparam int CLK_PERIOD   = 20;
    // Cycles to let pass once no write is pending: covers a dropped span
    // still moving through the three-stage pipe.
    localparam int DRAIN_CYCLES = 12;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RUN_CYCLES   = 600000;

    // Edge masks, one nibble per (x & 3): left keeps planes at and above x,
    // right keeps planes at and below x.
    localparam logic [15:0] LEFT_EDGE_MASKS  = 16'h8CEF;
    localparam logic [15:0] RIGHT_EDGE_MASKS = 16'hF731;

    typedef struct packed {
        logic [15:0] addr;
        logic [3:0]  mask;
        logic [8:0]  count;
        logic [7:0]  color;
        logic        last;
    } plane_write_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // row[11:0], span_left[23:12], span_right[35:24],
                            // fill_color[43:36]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // byte_address[15:0], plane_mask[19:16],
                            // byte_count[28:20], write_color[36:29]
    logic        m_tlast;   // last_write

    // Shadow copy of the clip window and page offset
    logic [9:0]  win_min_x;
    logic [10:0] win_max_x;
    logic [9:0]  win_min_y;
    logic [10:0] win_max_y;
    logic [15:0] win_page_base;

    plane_write_t pending_writes[$];
    int           fail_count;
    bit           no_idle;

    planar_span_write_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run
    initial begin
        #(CLK_PERIOD * RUN_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Idle length: mostly none or short, now and then long; none in bursts.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Work out the writes one accepted span causes and queue them.
    function automatic void predict_span_writes(input logic [11:0] row_f,
                                                input logic [11:0] left_f,
                                                input logic [11:0] right_f,
                                                input logic [7:0]  color);
        int          row;
        int          xs;
        int          xe;
        int          n;
        logic [15:0] addr;
        logic [3:0]  lmask;
        logic [3:0]  rmask;
        row = $signed(row_f);
        xs  = $signed(left_f);
        xe  = $signed(right_f);
        // drop rows outside the window, then clamp both ends
        if (row < int'(win_min_y) || row >= int'(win_max_y))
            return;
        if (xs < int'(win_min_x))
            xs = int'(win_min_x);
        if (xe >= int'(win_max_x))
            xe = int'(win_max_x) - 1;
        if (xe < xs)
            return;
        // row and xs are non-negative from here on
        addr  = 16'(int'(win_page_base) + row * int'(ROW_BYTES) + (xs >> 2));
        lmask = LEFT_EDGE_MASKS[4 * xs[1:0] +: 4];
        rmask = RIGHT_EDGE_MASKS[4 * xe[1:0] +: 4];
        n     = (xe - (xs & ~3)) >> 2;
        if (n == 0) begin
            pending_writes.push_back(plane_write_t'{addr, lmask & rmask, 9'd1, color, 1'b1});
        end else begin
            pending_writes.push_back(plane_write_t'{addr, lmask, 9'd1, color, 1'b0});
            if (n >= 2)
                pending_writes.push_back(plane_write_t'{addr + 16'd1, MASK_ALL, 9'(n - 1),
                                                        color, 1'b0});
            pending_writes.push_back(plane_write_t'{16'(addr + n), rmask, 9'd1, color, 1'b1});
        end
    endfunction

    // Drive one span, hold it until the transfer, predict, then idle a while.
    // With no idle, tvalid stays high into the next span.
    task automatic send_span(input int row, input int xs, input int xe, input int color);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, 8'(color), 12'(xe), 12'(xs), 12'(row)};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_span_writes(12'(row), 12'(xs), 12'(xe), 8'(color));
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop the input, wait for every pending write, then let the pipe empty.
    task automatic wait_until_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write one register; the shadow follows at the edge that writes it.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_CLIP_MIN_X: win_min_x     = value[9:0];
            REG_CLIP_MAX_X: win_max_x     = value[10:0];
            REG_CLIP_MIN_Y: win_min_y     = value[9:0];
            REG_CLIP_MAX_Y: win_max_y     = value[10:0];
            REG_PAGE_BASE:  win_page_base = value;
            default: ;
        endcase
    endtask

    // Reload the whole window while the block is idle.
    task automatic load_window(input int min_x, input int max_x, input int min_y,
                               input int max_y, input int base);
        wait_until_idle();
        write_reg(REG_CLIP_MIN_X, 16'(min_x));
        write_reg(REG_CLIP_MAX_X, 16'(max_x));
        write_reg(REG_CLIP_MIN_Y, 16'(min_y));
        write_reg(REG_CLIP_MAX_Y, 16'(max_y));
        write_reg(REG_PAGE_BASE, 16'(base));
        cfg_wr_en <= 1'b0;
    endtask

    // Directed spans under the reset window (320 x 240, page 0).
    task automatic test_reset_window();
        int k;
        send_span(0, 0, 0, 8'h00);          // one pixel, plane 0 only
        send_span(0, 5, 6, 8'hFF);          // inside one byte, merged mask
        send_span(1, 3, 4, 8'h5A);          // two bytes, no middle fill
        send_span(2, 1, 14, 8'hA5);         // left, middle, right
        send_span(239, 0, 319, 8'h3C);      // last row, full width
        send_span(240, 0, 10, 8'h11);       // row just below the window
        send_span(-1, 0, 10, 8'h22);        // row just above the window
        send_span(-2048, -2048, -2048, 8'h33);
        send_span(2047, 2047, 2047, 8'h44);
        send_span(10, -2048, 2047, 8'h81);  // clamped at both ends
        send_span(12, -20, -1, 8'h55);      // empty after left clamp
        send_span(13, 330, 400, 8'h66);     // empty after right clamp
        send_span(14, 50, 40, 8'h77);       // end before start
        // each left alignment once, each paired with a different right one
        for (k = 0; k < 4; k++)
            send_span(20 + k, 8 + k, 19 - k, 8'h90 + k);
    endtask

    // Widest window with a wrapping page, a one-pixel window, an empty one.
    task automatic test_window_extremes();
        load_window(0, 1024, 0, 1024, 16'hFFFF);
        send_span(1023, 0, 2047, 8'hFF);    // longest middle fill, address wraps
        send_span(1023, 1020, 1023, 8'h01);
        send_span(512, -2048, 1023, 8'h02);
        load_window(1023, 1024, 1023, 1024, 16'h1234);
        send_span(1023, 0, 2047, 8'h03);    // clamps to the single last pixel
        send_span(1022, 0, 2047, 8'h04);
        load_window(1023, 0, 1023, 0, 16'h0000);
        send_span(1023, 0, 2047, 8'h05);    // inverted window drops all
        send_span(0, 0, 0, 8'h06);
    endtask

    // Random windows; most spans land in or near the window, some are noise.
    task automatic test_random_spans();
        int phase;
        int k;
        int r;
        int min_x;
        int max_x;
        int min_y;
        int max_y;
        int swap;
        int lo_x;
        int hi_x;
        int row;
        int xs;
        int xe;
        for (phase = 0; phase < 6; phase++) begin
            min_x = $urandom_range(0, 1023);
            max_x = $urandom_range(0, 1024);
            min_y = $urandom_range(0, 1023);
            max_y = $urandom_range(0, 1024);
            // keep most windows ordered, let a few stay inverted
            if (max_x < min_x && $urandom_range(0, 4) != 0) begin
                swap = min_x; min_x = max_x; max_x = swap;
            end
            if (max_y < min_y && $urandom_range(0, 4) != 0) begin
                swap = min_y; min_y = max_y; max_y = swap;
            end
            case (phase)
                0:       load_window(0, 320, 0, 240, 0);
                1:       load_window(0, 1024, 0, 1024, $urandom_range(0, 65535));
                default: load_window(min_x, max_x, min_y, max_y, $urandom_range(0, 65535));
            endcase
            no_idle = (phase == 3);
            for (k = 0; k < 77; k++) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    // noise over the whole field range
                    row = int'($urandom_range(0, 4095)) - 2048;
                    xs  = int'($urandom_range(0, 4095)) - 2048;
                    xe  = int'($urandom_range(0, 4095)) - 2048;
                end else begin
                    if (r < 20 || win_max_y <= win_min_y)
                        row = ($urandom_range(0, 1) ? int'(win_min_y) : int'(win_max_y))
                              - 2 + int'($urandom_range(0, 3));
                    else
                        row = $urandom_range(win_min_y, win_max_y - 1);
                    lo_x = int'(win_min_x) - 8;
                    hi_x = int'(win_max_x) + 8;
                    if (hi_x < lo_x)
                        hi_x = lo_x + 64;
                    xs = lo_x + int'($urandom_range(0, hi_x - lo_x));
                    r  = $urandom_range(0, 99);
                    if (r < 50)
                        xe = xs + int'($urandom_range(0, 12));
                    else if (r < 85)
                        xe = xs + int'($urandom_range(0, 80));
                    else if (r < 95)
                        xe = xs + int'($urandom_range(0, hi_x - lo_x));
                    else
                        xe = xs - int'($urandom_range(1, 8));
                end
                send_span(row, xs, xe, $urandom_range(0, 255));
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: hold tready low for random stretches.
    initial begin
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    // Score each write transfer against the oldest pending write. Values read
    // here are the ones from before the edge, as the block saw them.
    always @(posedge aclk) begin : score_writes
        plane_write_t seen;
        plane_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.addr  = m_tdata[15:0];
            seen.mask  = m_tdata[19:16];
            seen.count = m_tdata[28:20];
            seen.color = m_tdata[36:29];
            seen.last  = m_tlast;
            if (pending_writes.size() == 0) begin
                report_mismatch("write with none pending, byte_address",
                                int'(seen.addr), 0);
            end else begin
                want = pending_writes.pop_front();
                if (seen.addr !== want.addr)
                    report_mismatch("byte_address", int'(seen.addr), int'(want.addr));
                if (seen.mask !== want.mask)
                    report_mismatch("plane_mask", int'(seen.mask), int'(want.mask));
                if (seen.count !== want.count)
                    report_mismatch("byte_count", int'(seen.count), int'(want.count));
                if (seen.color !== want.color)
                    report_mismatch("write_color", int'(seen.color), int'(want.color));
                if (seen.last !== want.last)
                    report_mismatch("last_write", int'(seen.last), int'(want.last));
            end
        end
    end

    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        fail_count    = 0;
        no_idle       = 1'b0;
        win_min_x     = 10'd0;
        win_max_x     = 11'd320;
        win_min_y     = 10'd0;
        win_max_y     = 11'd240;
        win_page_base = 16'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_reset_window();
        test_window_extremes();
        test_random_spans();

        // drain, then flag anything that never came out
        wait_until_idle();
        if (pending_writes.size() != 0)
            report_mismatch("writes left pending", pending_writes.size(), 0);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/psw_pkg.sv
rtl/psw_cfg_regs.sv
rtl/psw_span_plan.sv
rtl/psw_write_seq.sv
rtl/planar_span_write_generator.sv
dv/tb_planar_span_write_generator.sv
